@@ hw/rtl/s2cd_pkg.sv @@
package s2cd_pkg;

   localparam int STAGES = 11;

   localparam logic [31:0] EPOCH_DELTA   = 32'd2082841761;
   localparam logic [31:0] BIAS_RESET    = 32'd0 - EPOCH_DELTA;

   localparam logic [25:0] M_DAY         = 26'd50903317;
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [13:0] M_HOUR        = 14'd9321;
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [10:0] M_MIN         = 11'd1093;
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [16:0] M_WEEK        = 17'd74899;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
   localparam logic [15:0] WDAY_BIAS     = 16'd4;

   localparam logic [19:0] DAYS_TO_1970  = 20'd719468;
   localparam logic [19:0] ERA4_START    = 20'd584388;
   localparam logic [19:0] ERA5_START    = 20'd730485;
   localparam logic [16:0] M_1460        = 17'd91930;
   localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
   localparam logic [17:0] DAYS_LAST     = 18'd146096;
   localparam logic [18:0] M_365         = 19'd367720;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [11:0] YEAR_ERA4     = 12'd1600;
   localparam logic [11:0] YEAR_ERA5     = 12'd2000;
   localparam logic [11:0] M_153         = 12'd3427;
   localparam logic [11:0] M_5           = 12'd3277;
   localparam logic [7:0]  DAYS_5_MONTHS = 8'd153;
   localparam logic [11:0] YEAR_BASE     = 12'd1900;
   localparam logic [8:0]  MAR_TO_JAN    = 9'd306;
   localparam logic [8:0]  JAN_TO_MAR    = 9'd59;
   localparam logic [3:0]  MAR_MONTH     = 4'd2;
   localparam logic [3:0]  JAN_OFFSET    = 4'd10;

   typedef struct packed {
      logic [STAGES-1:0] en;
      logic [STAGES-1:0] vld;
   } ctl_type;

   typedef struct packed {
      logic [31:0] secs;
      logic [50:0] prod_day;
      logic [15:0] days;
      logic [16:0] rem;
      logic [26:0] hprod;
      logic [15:0] d4;
      logic [32:0] wprod;
      logic [17:0] doe;
      logic        era5;
      logic [4:0]  hour_v;
      logic [11:0] ms;
      logic [2:0]  wday;
      logic [32:0] q1prod;
      logic [2:0]  q2;
      logic        q3;
      logic [20:0] mprod;
      logic [17:0] n;
      logic [5:0]  minute_v;
      logic [5:0]  second_v;
      logic [36:0] yprod;
      logic [8:0]  doy;
      logic [11:0] y;
      logic        leap;
      logic [22:0] mpprod;
      logic [3:0]  mon;
      logic [7:0]  years;
      logic [8:0]  yday;
      logic [22:0] dprod;
      logic [4:0]  mday;
   } item_type;

endpackage

@@ hw/rtl/s2cd_flow.sv @@
module s2cd_flow
   import s2cd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         if (en[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[STAGES-1];
   assign ctl.en    = en;
   assign ctl.vld   = vld_ff;

   a_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(vld_ff) == $past($countones(vld_ff))
               + ($past(req_valid && req_ready) ? 1 : 0)
               - ($past(rsp_valid && rsp_ready) ? 1 : 0))
      else $error("beat count through the pipeline is off");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_full: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("full stalled pipeline still takes a beat");

   a_block: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[0])
      else $error("input blocked while first stage is empty");

endmodule

@@ hw/rtl/seconds_to_civil_date_top.sv @@
// Converts a local timestamp in seconds into a broken-down GMT calendar
// date (second, minute, hour, day of month, month 0-11, years since 1900,
// weekday, day of year from January 1). The zone offset written on the
// csr port is subtracted together with the fixed epoch delta, modulo 2^32,
// before conversion; write it only while no beat is in flight. The block
// takes one beat per cycle unless a stall at the result side backs up to
// the first stage. Results leave an eleven-stage register pipeline in which
// most divisions by a constant are reciprocal multiplies, spread over the
// stages; those by 36524 and by 100 are compares. A stall at the result side
// holds the run of full stages ending at the output; empty stages still fill.
module seconds_to_civil_date_top
   import s2cd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [17:0] csr_zone_offset_seconds,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_time_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [7:0]  rsp_years_since_1900,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);

   ctl_type  ctl;
   logic [31:0] bias_ff;
   logic [31:0] bias_in;
   item_type pipe_ff [STAGES];
   item_type pipe_in [STAGES];

   s2cd_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   assign bias_in = 32'd0 - {{14{csr_zone_offset_seconds[17]}}, csr_zone_offset_seconds}
                    - EPOCH_DELTA;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= BIAS_RESET;
      end else if (csr_write_en) begin
         bias_ff <= bias_in;
      end
   end

   always_comb begin
      logic [32:0] day_base;
      logic [32:0] rem_w;
      logic [19:0] shifted;
      logic [19:0] doe_w;
      logic [16:0] hour_base;
      logic [16:0] ms_w;
      logic [13:0] wq;
      logic [16:0] wq7;
      logic [15:0] wtmp;
      logic [6:0]  q1;
      logic [5:0]  min_q;
      logic [11:0] min_base;
      logic [11:0] sec_w;
      logic [8:0]  yoe;
      logic [1:0]  c100;
      logic [17:0] yr_base;
      logic [17:0] doy_w;
      logic [11:0] mnum;
      logic [3:0]  mp;
      logic [11:0] dnum;
      logic [8:0]  dq;
      logic [8:0]  mday_w;
      logic [11:0] civil_y;
      logic [11:0] years_w;

      pipe_in[0]      = pipe_ff[0];
      pipe_in[0].secs = req_time_seconds + bias_ff;

      pipe_in[1]          = pipe_ff[0];
      pipe_in[1].prod_day = 51'(pipe_ff[0].secs[31:7]) * 51'(M_DAY);

      pipe_in[2]      = pipe_ff[1];
      pipe_in[2].days = pipe_ff[1].prod_day[50:35];
      day_base        = 33'(pipe_in[2].days) * 33'(SEC_PER_DAY);
      rem_w           = {1'b0, pipe_ff[1].secs} - day_base;
      pipe_in[2].rem  = rem_w[16:0];

      pipe_in[3]       = pipe_ff[2];
      pipe_in[3].hprod = 27'(pipe_ff[2].rem[16:4]) * 27'(M_HOUR);
      pipe_in[3].d4    = pipe_ff[2].days + WDAY_BIAS;
      pipe_in[3].wprod = 33'(pipe_in[3].d4) * 33'(M_WEEK);
      shifted          = {4'd0, pipe_ff[2].days} + DAYS_TO_1970;
      pipe_in[3].era5  = shifted >= ERA5_START;
      doe_w            = shifted - (pipe_in[3].era5 ? ERA5_START : ERA4_START);
      pipe_in[3].doe   = doe_w[17:0];

      pipe_in[4]        = pipe_ff[3];
      pipe_in[4].hour_v = pipe_ff[3].hprod[25:21];
      hour_base         = 17'(pipe_in[4].hour_v) * 17'(SEC_PER_HOUR);
      ms_w              = pipe_ff[3].rem - hour_base;
      pipe_in[4].ms     = ms_w[11:0];
      wq                = pipe_ff[3].wprod[32:19];
      wq7               = 17'(wq) * 17'(DAYS_PER_WEEK);
      wtmp              = pipe_ff[3].d4 - wq7[15:0];
      pipe_in[4].wday   = wtmp[2:0];
      pipe_in[4].q1prod = 33'(pipe_ff[3].doe[17:2]) * 33'(M_1460);
      pipe_in[4].q2     = 3'(pipe_ff[3].doe >= DAYS_PER_CENT)
                        + 3'(pipe_ff[3].doe >= 18'(2 * DAYS_PER_CENT))
                        + 3'(pipe_ff[3].doe >= 18'(3 * DAYS_PER_CENT))
                        + 3'(pipe_ff[3].doe >= DAYS_LAST);
      pipe_in[4].q3     = pipe_ff[3].doe == DAYS_LAST;

      pipe_in[5]       = pipe_ff[4];
      pipe_in[5].mprod = 21'(pipe_ff[4].ms[11:2]) * 21'(M_MIN);
      q1               = pipe_ff[4].q1prod[31:25];
      pipe_in[5].n     = pipe_ff[4].doe - {11'd0, q1} + {15'd0, pipe_ff[4].q2}
                       - {17'd0, pipe_ff[4].q3};

      pipe_in[6]          = pipe_ff[5];
      min_q               = pipe_ff[5].mprod[19:14];
      pipe_in[6].minute_v = min_q;
      min_base            = 12'(min_q) * 12'(SEC_PER_MIN);
      sec_w               = pipe_ff[5].ms - min_base;
      pipe_in[6].second_v = sec_w[5:0];
      pipe_in[6].yprod    = 37'(pipe_ff[5].n) * 37'(M_365);

      pipe_in[7]      = pipe_ff[6];
      yoe             = pipe_ff[6].yprod[35:27];
      c100            = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
      yr_base         = 18'(yoe) * 18'(DAYS_PER_YEAR) + {11'd0, yoe[8:2]}
                        - {16'd0, c100};
      doy_w           = pipe_ff[6].doe - yr_base;
      pipe_in[7].doy  = doy_w[8:0];
      pipe_in[7].y    = {3'd0, yoe} + (pipe_ff[6].era5 ? YEAR_ERA5 : YEAR_ERA4);
      pipe_in[7].leap = (yoe[1:0] == 2'd0) && (yoe != 9'd100) && (yoe != 9'd200)
                        && (yoe != 9'd300);

      pipe_in[8]        = pipe_ff[7];
      mnum              = 12'(pipe_ff[7].doy) * 12'd5 + 12'd2;
      pipe_in[8].mpprod = 23'(mnum[10:0]) * 23'(M_153);

      pipe_in[9]       = pipe_ff[8];
      mp               = pipe_ff[8].mpprod[22:19];
      pipe_in[9].mon   = (mp < JAN_OFFSET) ? mp + MAR_MONTH : mp - JAN_OFFSET;
      civil_y          = pipe_ff[8].y + {11'd0, pipe_in[9].mon <= 4'd1};
      years_w          = civil_y - YEAR_BASE;
      pipe_in[9].years = years_w[7:0];
      pipe_in[9].yday  = (pipe_ff[8].doy >= MAR_TO_JAN)
                       ? pipe_ff[8].doy - MAR_TO_JAN
                       : pipe_ff[8].doy + JAN_TO_MAR + {8'd0, pipe_ff[8].leap};
      dnum             = 12'(mp) * 12'(DAYS_5_MONTHS) + 12'd2;
      pipe_in[9].dprod = 23'(dnum[10:0]) * 23'(M_5);

      pipe_in[10]      = pipe_ff[9];
      dq               = pipe_ff[9].dprod[22:14];
      mday_w           = pipe_ff[9].doy - dq + 9'd1;
      pipe_in[10].mday = mday_w[4:0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (ctl.en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_second           = pipe_ff[STAGES-1].second_v;
   assign rsp_minute           = pipe_ff[STAGES-1].minute_v;
   assign rsp_hour             = pipe_ff[STAGES-1].hour_v;
   assign rsp_day_of_month     = pipe_ff[STAGES-1].mday;
   assign rsp_month            = pipe_ff[STAGES-1].mon;
   assign rsp_years_since_1900 = pipe_ff[STAGES-1].years;
   assign rsp_weekday          = pipe_ff[STAGES-1].wday;
   assign rsp_day_of_year      = pipe_ff[STAGES-1].yday;

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second < 6'd60 && rsp_minute < 6'd60 && rsp_hour < 5'd24
                    && rsp_month < 4'd12 && rsp_weekday < 3'd7)
      else $error("time or month field out of range");

   a_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_of_month != 5'd0 && rsp_day_of_year < 9'd366
                    && rsp_years_since_1900 >= 8'd70 && rsp_years_since_1900 <= 8'd206)
      else $error("date field out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pipe_ff[STAGES-1]))
      else $error("output stage changed under a stall");

endmodule
